FILE: src/type_length_string_decoder_macros.svh
// Assertion macros for the type/length string decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TYPE_LENGTH_STRING_DECODER_MACROS_SVH
`define TYPE_LENGTH_STRING_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define TLSD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tlsd assertion failed");
`define TLSD_ASSERT_NEVER(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("tlsd forbidden condition seen");
`else
`define TLSD_ASSERT(label, clk, rst_n, prop)
`define TLSD_ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

FILE: src/tlsd_pkg.sv
// Shared types, codes and the BCD-plus character table for the string decoder.
// No dependencies; used by tlsd_step and type_length_string_decoder.
package tlsd_pkg;

	typedef enum logic [1:0] {
		CT_UNICODE  = 2'd0,
		CT_BCD_PLUS = 2'd1,
		CT_ASCII6   = 2'd2,
		CT_ASCII8   = 2'd3
	} code_type_t;

	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2
	} phase_t;

	localparam logic [7:0] ASCII6_OFFSET = 8'h20;

	typedef struct packed {
		code_type_t  code_type;
		logic [4:0]  chars_left;
		phase_t      bit_phase;
		logic [5:0]  pending_bits;
		logic        field_active;
	} dec_state_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       char_valid;
		logic       end_of_string;
	} result_t;

	function automatic logic [7:0] bcd_plus_char(input logic [3:0] digit);
		logic [7:0] c;
		unique case (digit)
			4'hA: c = 8'h20;
			4'hB: c = 8'h2D;
			4'hC: c = 8'h2E;
			4'hD: c = 8'h3A;
			4'hE: c = 8'h2C;
			4'hF: c = 8'h5F;
			default: c = {4'h3, digit};
		endcase
		return c;
	endfunction

endpackage

FILE: src/type_length_string_decoder.sv
// Results are registered: a result is offered in the cycle after its input transfer.
// Throughput: one input byte per cycle while each byte yields at most one result and
// m_tready stays high; a byte yielding two results holds off the input while the
// two-entry result register drains through the single output port.
// Reset: asynchronous, active low; clears the field state, empties the result
// register and sets max_chars to 31.
// Top level of the type/length string decoder; depends on tlsd_pkg, tlsd_step
// and type_length_string_decoder_macros.svh.
`include "type_length_string_decoder_macros.svh"
module type_length_string_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       s_tuser,   // first_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // char_code
	output logic       m_tuser,   // char_valid
	output logic       m_tlast    // end_of_string
);

	logic [4:0]            max_chars_q;
	tlsd_pkg::dec_state_t  state_q;
	tlsd_pkg::dec_state_t  state_next;
	tlsd_pkg::result_t     res0;
	tlsd_pkg::result_t     res1;
	tlsd_pkg::result_t     slot0_s1;
	tlsd_pkg::result_t     slot1_s1;
	logic [1:0]            num_results;
	logic [1:0]            count_q;
	logic                  in_xfer;
	logic                  out_xfer;

	tlsd_step u_step (
		.data_byte  (s_tdata),
		.first_byte (s_tuser),
		.last_byte  (s_tlast),
		.max_chars  (max_chars_q),
		.state      (state_q),
		.state_next (state_next),
		.num_results(num_results),
		.res0       (res0),
		.res1       (res1)
	);

	assign m_tvalid = (count_q != 2'd0);
	assign out_xfer = m_tvalid && m_tready;
	assign s_tready = (count_q == 2'd0) || (count_q == 2'd1 && m_tready);
	assign in_xfer  = s_tvalid && s_tready;

	assign m_tdata = slot0_s1.char_code;
	assign m_tuser = slot0_s1.char_valid;
	assign m_tlast = slot0_s1.end_of_string;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= 5'd31;
			state_q <= '0;
			count_q <= 2'd0;
		end else begin
			if (cfg_we) begin
				max_chars_q <= cfg_wdata;
			end
			if (in_xfer) begin
				state_q <= state_next;
				count_q <= num_results;
			end else if (out_xfer) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			slot0_s1 <= res0;
			slot1_s1 <= res1;
		end else if (out_xfer) begin
			slot0_s1 <= slot1_s1;
		end
	end

	`TLSD_ASSERT_NEVER(a_count_range, clk, arst_n, count_q == 2'd3)
	`TLSD_ASSERT(a_ready_room, clk, arst_n, s_tready |-> count_q != 2'd2)
	`TLSD_ASSERT(a_marker_ends, clk, arst_n, (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 8'h00))
	`TLSD_ASSERT(a_pair_head, clk, arst_n, (count_q == 2'd2) |-> (m_tuser && !m_tlast))
	`TLSD_ASSERT(a_end_closes, clk, arst_n, (in_xfer && num_results != 2'd0 && ((num_results == 2'd2 && res1.end_of_string) || (num_results == 2'd1 && res0.end_of_string))) |=> !state_q.field_active)

endmodule

FILE: src/tlsd_step.sv
// Combinational decode of one input byte: next field state and up to two results.
// Depends on tlsd_pkg.
module tlsd_step (
	input  logic [7:0]             data_byte,
	input  logic                   first_byte,
	input  logic                   last_byte,
	input  logic [4:0]             max_chars,
	input  tlsd_pkg::dec_state_t   state,
	output tlsd_pkg::dec_state_t   state_next,
	output logic [1:0]             num_results,
	output tlsd_pkg::result_t      res0,
	output tlsd_pkg::result_t      res1
);

	logic [7:0] cand0;
	logic [7:0] cand1;
	logic       want0;
	logic       want1;
	logic       emit0;
	logic       emit1;
	logic [4:0] left1;
	logic [4:0] left2;
	logic [4:0] len;
	logic [4:0] clamped;

	always_comb begin
		cand0 = 8'h00;
		cand1 = 8'h00;
		want0 = 1'b0;
		want1 = 1'b0;
		state_next = state;
		case (state.code_type)
			tlsd_pkg::CT_BCD_PLUS: begin
				cand0 = tlsd_pkg::bcd_plus_char(data_byte[3:0]);
				cand1 = tlsd_pkg::bcd_plus_char(data_byte[7:4]);
				want0 = 1'b1;
				want1 = 1'b1;
			end
			tlsd_pkg::CT_ASCII6: begin
				unique case (state.bit_phase)
					tlsd_pkg::PH_1: begin
						cand0 = {2'b00, data_byte[3:0], state.pending_bits[1:0]}
							+ tlsd_pkg::ASCII6_OFFSET;
						want0 = 1'b1;
						state_next.pending_bits = {2'b00, data_byte[7:4]};
						state_next.bit_phase = tlsd_pkg::PH_2;
					end
					tlsd_pkg::PH_2: begin
						cand0 = {2'b00, data_byte[1:0], state.pending_bits[3:0]}
							+ tlsd_pkg::ASCII6_OFFSET;
						cand1 = {2'b00, data_byte[7:2]} + tlsd_pkg::ASCII6_OFFSET;
						want0 = 1'b1;
						want1 = 1'b1;
						state_next.pending_bits = 6'd0;
						state_next.bit_phase = tlsd_pkg::PH_0;
					end
					default: begin
						cand0 = {2'b00, data_byte[5:0]} + tlsd_pkg::ASCII6_OFFSET;
						want0 = 1'b1;
						state_next.pending_bits = {4'd0, data_byte[7:6]};
						state_next.bit_phase = tlsd_pkg::PH_1;
					end
				endcase
			end
			tlsd_pkg::CT_ASCII8: begin
				cand0 = data_byte;
				want0 = 1'b1;
			end
			default: begin
			end
		endcase

		emit0 = want0 && (state.chars_left != 5'd0);
		left1 = state.chars_left - {4'd0, emit0};
		emit1 = want1 && (left1 != 5'd0);
		left2 = left1 - {4'd0, emit1};
		state_next.chars_left = left2;

		res0 = '{char_code: cand0, char_valid: 1'b1, end_of_string: 1'b0};
		res1 = '{char_code: cand1, char_valid: 1'b1, end_of_string: 1'b0};
		num_results = {1'b0, emit0} + {1'b0, emit1};

		len = data_byte[4:0];
		clamped = (len > max_chars) ? max_chars : len;

		if (first_byte) begin
			state_next.code_type = tlsd_pkg::code_type_t'(data_byte[7:6]);
			state_next.chars_left =
				(data_byte[7:6] == tlsd_pkg::CT_UNICODE) ? 5'd0 : clamped;
			state_next.bit_phase = tlsd_pkg::PH_0;
			state_next.pending_bits = 6'd0;
			state_next.field_active = 1'b1;
			num_results = 2'd0;
			if (state_next.chars_left == 5'd0 || last_byte) begin
				res0 = '{char_code: 8'h00, char_valid: 1'b0, end_of_string: 1'b1};
				num_results = 2'd1;
				state_next.field_active = 1'b0;
			end
		end else if (!state.field_active) begin
			state_next = state;
			num_results = 2'd0;
		end else if (left2 == 5'd0 || last_byte) begin
			state_next.field_active = 1'b0;
			if (emit1) begin
				res1.end_of_string = 1'b1;
			end else if (emit0) begin
				res0.end_of_string = 1'b1;
			end else begin
				res0 = '{char_code: 8'h00, char_valid: 1'b0, end_of_string: 1'b1};
				num_results = 2'd1;
			end
		end
	end

endmodule
